[hdl/tfd_pkg.sv]
package tfd_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned CODE_W   = 8;
    localparam int unsigned LEN_W    = 10;
    localparam int unsigned LIMIT_W  = 11;
    localparam int unsigned COUNT_W  = 11;
    localparam int unsigned TOTAL_W  = 12;
    localparam int unsigned CLASS_W  = 3;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    // start pattern of a valid header
    localparam logic [BYTE_W-1:0] START_BYTE0 = 8'h41;
    localparam logic [BYTE_W-1:0] START_BYTE1 = 8'h00;
    localparam logic [BYTE_W-1:0] START_BYTE2 = 8'h29;

    // frame class codes
    localparam logic [CLASS_W-1:0] CLASS_OPERATING = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_PARAMETER = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_LABEL     = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN   = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_NO_START  = 3'd4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_OPER_CODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OPER_LEN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_CODE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LABEL_LEN   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN_LIM = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DRAIN_LIM   = 3'd7;

    // register reset values
    localparam logic [CODE_W-1:0]  RST_OPER_CODE   = 8'h4A;
    localparam logic [LEN_W-1:0]   RST_OPER_LEN    = 10'd275;
    localparam logic [CODE_W-1:0]  RST_PARAM_CODE  = 8'h56;
    localparam logic [LEN_W-1:0]   RST_PARAM_LEN   = 10'd784;
    localparam logic [CODE_W-1:0]  RST_LABEL_CODE  = 8'h42;
    localparam logic [LEN_W-1:0]   RST_LABEL_LEN   = 10'd32;
    localparam logic [LIMIT_W-1:0] RST_UNKNOWN_LIM = 11'd1000;
    localparam logic [LIMIT_W-1:0] RST_DRAIN_LIM   = 11'd2000;

    localparam logic [TOTAL_W-1:0] HEADER_BYTES = 12'd4;

endpackage

[hdl/typed_frame_deframer_xor_check.sv]
// A result is registered and shows on the output in the cycle after the item that ends a frame.
// Throughput: one item per cycle while o_in_stall is low; the byte counter, target compare and
// running XOR all settle combinationally between the input handshake and the result register.
// Input stall follows output stall only while a result is held in the output register.
// Reset (i_rst_n low, synchronous): header phase, counters and XOR cleared, pattern flag set,
// registers back to their defaults, output register empty.
module typed_frame_deframer_xor_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input item channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_command,
    input  logic [tfd_pkg::BYTE_W-1:0]     i_rx_byte,
    // result item channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [tfd_pkg::CLASS_W-1:0]    o_frame_class,
    output logic [tfd_pkg::CODE_W-1:0]     o_type_byte,
    output logic [tfd_pkg::TOTAL_W-1:0]    o_byte_total,
    output logic                           o_length_complete,
    output logic                           o_checksum_good
);
    import tfd_pkg::*;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BODY,
        PH_DRAIN
    } t_phase;

    // configuration registers
    logic [CODE_W-1:0]  r_oper_code,  r_param_code, r_label_code;
    logic [LEN_W-1:0]   r_oper_len,   r_param_len,  r_label_len;
    logic [LIMIT_W-1:0] r_unknown_lim, r_drain_lim;

    // frame state
    t_phase             r_phase,      n_phase;
    logic [1:0]         r_hdr_count,  n_hdr_count;
    logic               r_pattern_ok, n_pattern_ok;
    logic [CODE_W-1:0]  r_held_type,  n_held_type;
    logic [CLASS_W-1:0] r_held_class, n_held_class;
    logic [COUNT_W-1:0] r_body_count, n_body_count;
    logic [COUNT_W-1:0] r_body_target, n_body_target;
    logic [BYTE_W-1:0]  r_xor,        n_xor;
    logic [BYTE_W-1:0]  r_prev_byte,  n_prev_byte;

    // result register
    logic               r_out_valid;
    logic [CLASS_W-1:0] r_out_class;
    logic [CODE_W-1:0]  r_out_type;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_complete;
    logic               r_out_good;

    logic               in_accept;
    logic               emit;
    logic               emit_complete;
    logic               emit_good;
    logic [COUNT_W-1:0] emit_count;
    logic [COUNT_W-1:0] body_inc;

    // The output register frees itself when empty or when its item is taken this cycle.
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign body_inc = r_body_count + COUNT_W'(1);

    always_comb begin
        n_phase       = r_phase;
        n_hdr_count   = r_hdr_count;
        n_pattern_ok  = r_pattern_ok;
        n_held_type   = r_held_type;
        n_held_class  = r_held_class;
        n_body_count  = r_body_count;
        n_body_target = r_body_target;
        n_xor         = r_xor;
        n_prev_byte   = r_prev_byte;
        emit          = 1'b0;
        emit_complete = 1'b0;
        emit_count    = '0;

        if (i_command) begin
            // Line idle: ignore in the header, close the frame elsewhere.
            emit_count = r_body_count;
            if (r_phase == PH_BODY || r_phase == PH_DRAIN) begin
                emit          = 1'b1;
                emit_complete = (r_body_count >= r_body_target);
            end
        end else begin
            n_xor       = r_xor ^ i_rx_byte;
            n_prev_byte = i_rx_byte;
            unique case (r_phase) inside
                PH_BODY, PH_DRAIN: begin
                    n_body_count = body_inc;
                    emit_count   = body_inc;
                    if (body_inc >= r_body_target) begin
                        emit          = 1'b1;
                        emit_complete = 1'b1;
                    end
                end
                default: begin
                    // header collection; an unused phase code behaves as header
                    if (r_hdr_count == 2'd0 && i_rx_byte != START_BYTE0) n_pattern_ok = 1'b0;
                    if (r_hdr_count == 2'd1 && i_rx_byte != START_BYTE1) n_pattern_ok = 1'b0;
                    if (r_hdr_count == 2'd2 && i_rx_byte != START_BYTE2) n_pattern_ok = 1'b0;
                    if (r_hdr_count != 2'd3) begin
                        n_hdr_count = r_hdr_count + 2'd1;
                        n_phase     = PH_HEADER;
                    end else begin
                        n_held_type  = i_rx_byte;
                        n_body_count = '0;
                        n_hdr_count  = 2'd0;
                        if (!r_pattern_ok) begin
                            n_held_class  = CLASS_NO_START;
                            n_body_target = r_drain_lim;
                            n_phase       = PH_DRAIN;
                        end else begin
                            // operating wins over parameter, parameter over label
                            if (i_rx_byte == r_oper_code) begin
                                n_held_class  = CLASS_OPERATING;
                                n_body_target = COUNT_W'(r_oper_len);
                            end else if (i_rx_byte == r_param_code) begin
                                n_held_class  = CLASS_PARAMETER;
                                n_body_target = COUNT_W'(r_param_len);
                            end else if (i_rx_byte == r_label_code) begin
                                n_held_class  = CLASS_LABEL;
                                n_body_target = COUNT_W'(r_label_len);
                            end else begin
                                n_held_class  = CLASS_UNKNOWN;
                                n_body_target = r_unknown_lim;
                            end
                            n_phase = PH_BODY;
                        end
                        // a zero length closes the frame on the type byte
                        if (n_body_target == '0) begin
                            emit          = 1'b1;
                            emit_complete = 1'b1;
                        end
                    end
                end
            endcase
        end

        // XOR of all bytes but the last: running XOR with the last byte removed again
        emit_good = (n_held_class != CLASS_NO_START) && ((n_xor ^ n_prev_byte) == '0);

        if (emit) begin
            n_phase      = PH_HEADER;
            n_hdr_count  = 2'd0;
            n_pattern_ok = 1'b1;
            n_body_count = '0;
            n_xor        = '0;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oper_code   <= RST_OPER_CODE;
            r_oper_len    <= RST_OPER_LEN;
            r_param_code  <= RST_PARAM_CODE;
            r_param_len   <= RST_PARAM_LEN;
            r_label_code  <= RST_LABEL_CODE;
            r_label_len   <= RST_LABEL_LEN;
            r_unknown_lim <= RST_UNKNOWN_LIM;
            r_drain_lim   <= RST_DRAIN_LIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_OPER_CODE:   r_oper_code   <= i_cfg_data[CODE_W-1:0];
                REG_OPER_LEN:    r_oper_len    <= i_cfg_data[LEN_W-1:0];
                REG_PARAM_CODE:  r_param_code  <= i_cfg_data[CODE_W-1:0];
                REG_PARAM_LEN:   r_param_len   <= i_cfg_data[LEN_W-1:0];
                REG_LABEL_CODE:  r_label_code  <= i_cfg_data[CODE_W-1:0];
                REG_LABEL_LEN:   r_label_len   <= i_cfg_data[LEN_W-1:0];
                REG_UNKNOWN_LIM: r_unknown_lim <= i_cfg_data[LIMIT_W-1:0];
                REG_DRAIN_LIM:   r_drain_lim   <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // frame state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_hdr_count   <= 2'd0;
            r_pattern_ok  <= 1'b1;
            r_held_type   <= '0;
            r_held_class  <= CLASS_OPERATING;
            r_body_count  <= '0;
            r_body_target <= '0;
            r_xor         <= '0;
            r_prev_byte   <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase       <= n_phase;
                r_hdr_count   <= n_hdr_count;
                r_pattern_ok  <= n_pattern_ok;
                r_held_type   <= n_held_type;
                r_held_class  <= n_held_class;
                r_body_count  <= n_body_count;
                r_body_target <= n_body_target;
                r_xor         <= n_xor;
                r_prev_byte   <= n_prev_byte;
            end
            // advance the result register whenever it is free
            if (!o_in_stall) begin
                r_out_valid <= in_accept & emit;
            end
        end
        if (!o_in_stall && in_accept && emit) begin
            r_out_class    <= n_held_class;
            r_out_type     <= n_held_type;
            r_out_total    <= HEADER_BYTES + TOTAL_W'(emit_count);
            r_out_complete <= emit_complete;
            r_out_good     <= emit_good;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_frame_class     = r_out_class;
    assign o_type_byte       = r_out_type;
    assign o_byte_total      = r_out_total;
    assign o_length_complete = r_out_complete;
    assign o_checksum_good   = r_out_good;

`ifndef SYNTH
    // a timeout inside the header never produces a result
    a_hdr_timeout_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && i_command && r_phase == PH_HEADER |=> !o_out_valid)
        else $error("result after header timeout");

    // closing a frame returns to a clean header phase
    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept && emit |=> r_phase == PH_HEADER && r_body_count == '0 &&
                              r_hdr_count == 2'd0 && r_pattern_ok && r_xor == '0)
        else $error("frame state not cleared after result");

    // frames without start pattern never pass the check
    a_no_start_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_class == CLASS_NO_START |-> !o_checksum_good)
        else $error("checksum good on frame without start pattern");

    // a body phase always has a non-zero target and the count stays below it
    a_count_below_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_body_target != '0 && r_body_count < r_body_target)
        else $error("body count reached target without a result");
`endif

endmodule

[tb/typed_frame_deframer_xor_check_checker.sv]
module typed_frame_deframer_xor_check_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_command,
    input  logic [tfd_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [tfd_pkg::CLASS_W-1:0]    i_frame_class,
    input  logic [tfd_pkg::CODE_W-1:0]     i_type_byte,
    input  logic [tfd_pkg::TOTAL_W-1:0]    i_byte_total,
    input  logic                           i_length_complete,
    input  logic                           i_checksum_good,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_frames_checked,
    output logic                           o_at_boundary,
    output logic                           o_in_header
);
    import tfd_pkg::*;

    typedef enum logic [1:0] {SCAN_HEADER, SCAN_BODY, SCAN_DRAIN} t_scan_phase;

    typedef struct packed {
        logic [CLASS_W-1:0] frame_class;
        logic [CODE_W-1:0]  type_byte;
        logic [TOTAL_W-1:0] byte_total;
        logic               length_complete;
        logic               checksum_good;
    } t_frame_report;

    // register copy
    logic [CODE_W-1:0]  oper_code, param_code, label_code;
    logic [LEN_W-1:0]   oper_len, param_len, label_len;
    logic [LIMIT_W-1:0] unknown_lim, drain_lim;

    // deframer state
    t_scan_phase        scan_phase;
    logic [2:0]         hdr_count;
    logic               start_seen;
    logic [CODE_W-1:0]  cur_type;
    logic [CLASS_W-1:0] cur_class;
    logic [COUNT_W-1:0] body_count;
    logic [COUNT_W-1:0] body_target;
    logic [BYTE_W-1:0]  xor_acc;
    logic [BYTE_W-1:0]  last_byte;

    t_frame_report      expected_frames[$];
    int                 fails = 0;
    int                 checked = 0;

    task automatic close_frame(input logic done);
        t_frame_report r;
        r.frame_class     = cur_class;
        r.type_byte       = cur_type;
        r.byte_total      = HEADER_BYTES + TOTAL_W'(body_count);
        r.length_complete = done;
        // XOR over every byte but the last; never good without a start pattern
        r.checksum_good   = (cur_class != CLASS_NO_START) && ((xor_acc ^ last_byte) == '0);
        expected_frames.push_back(r);
        scan_phase = SCAN_HEADER;
        hdr_count  = '0;
        start_seen = 1'b1;
        body_count = '0;
        xor_acc    = '0;
    endtask

    task automatic predict_item(input logic is_timeout, input logic [BYTE_W-1:0] b);
        if (is_timeout) begin
            // a timeout inside the header is dropped
            if (scan_phase != SCAN_HEADER)
                close_frame(body_count >= body_target);
        end else begin
            xor_acc   = xor_acc ^ b;
            last_byte = b;
            if (scan_phase == SCAN_HEADER) begin
                if (hdr_count == 3'd0 && b != START_BYTE0) start_seen = 1'b0;
                if (hdr_count == 3'd1 && b != START_BYTE1) start_seen = 1'b0;
                if (hdr_count == 3'd2 && b != START_BYTE2) start_seen = 1'b0;
                if (hdr_count < 3'd3) begin
                    hdr_count++;
                end else begin
                    cur_type   = b;
                    body_count = '0;
                    hdr_count  = '0;
                    if (!start_seen) begin
                        cur_class   = CLASS_NO_START;
                        body_target = drain_lim;
                        scan_phase  = SCAN_DRAIN;
                    end else begin
                        scan_phase = SCAN_BODY;
                        if (b == oper_code) begin
                            cur_class   = CLASS_OPERATING;
                            body_target = COUNT_W'(oper_len);
                        end else if (b == param_code) begin
                            cur_class   = CLASS_PARAMETER;
                            body_target = COUNT_W'(param_len);
                        end else if (b == label_code) begin
                            cur_class   = CLASS_LABEL;
                            body_target = COUNT_W'(label_len);
                        end else begin
                            cur_class   = CLASS_UNKNOWN;
                            body_target = unknown_lim;
                        end
                    end
                    if (body_target == '0)
                        close_frame(1'b1);
                end
            end else begin
                body_count++;
                if (body_count >= body_target)
                    close_frame(1'b1);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                               input logic [TOTAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_frame_report want;
        if (!i_rst_n) begin
            oper_code   = RST_OPER_CODE;
            oper_len    = RST_OPER_LEN;
            param_code  = RST_PARAM_CODE;
            param_len   = RST_PARAM_LEN;
            label_code  = RST_LABEL_CODE;
            label_len   = RST_LABEL_LEN;
            unknown_lim = RST_UNKNOWN_LIM;
            drain_lim   = RST_DRAIN_LIM;
            scan_phase  = SCAN_HEADER;
            hdr_count   = '0;
            start_seen  = 1'b1;
            cur_type    = '0;
            cur_class   = '0;
            body_count  = '0;
            body_target = '0;
            xor_acc     = '0;
            last_byte   = '0;
            expected_frames.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_OPER_CODE:   oper_code   = i_cfg_data[CODE_W-1:0];
                    REG_OPER_LEN:    oper_len    = i_cfg_data[LEN_W-1:0];
                    REG_PARAM_CODE:  param_code  = i_cfg_data[CODE_W-1:0];
                    REG_PARAM_LEN:   param_len   = i_cfg_data[LEN_W-1:0];
                    REG_LABEL_CODE:  label_code  = i_cfg_data[CODE_W-1:0];
                    REG_LABEL_LEN:   label_len   = i_cfg_data[LEN_W-1:0];
                    REG_UNKNOWN_LIM: unknown_lim = i_cfg_data[LIMIT_W-1:0];
                    REG_DRAIN_LIM:   drain_lim   = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_item(i_command, i_rx_byte);
            if (i_out_valid && !i_out_stall) begin
                if (expected_frames.size() == 0) begin
                    $error("unexpected frame report: class %0d, type %0d, total %0d",
                           i_frame_class, i_type_byte, i_byte_total);
                    fails++;
                end else begin
                    want = expected_frames.pop_front();
                    check_field("frame_class", TOTAL_W'(want.frame_class),
                                TOTAL_W'(i_frame_class));
                    check_field("type_byte", TOTAL_W'(want.type_byte),
                                TOTAL_W'(i_type_byte));
                    check_field("byte_total", want.byte_total, i_byte_total);
                    check_field("length_complete", TOTAL_W'(want.length_complete),
                                TOTAL_W'(i_length_complete));
                    check_field("checksum_good", TOTAL_W'(want.checksum_good),
                                TOTAL_W'(i_checksum_good));
                    checked++;
                end
            end
        end
        o_fail_count     <= fails;
        o_pending        <= expected_frames.size();
        o_frames_checked <= checked;
        o_at_boundary    <= (scan_phase == SCAN_HEADER) && (hdr_count == '0);
        o_in_header      <= (scan_phase == SCAN_HEADER);
    end

endmodule

[tb/typed_frame_deframer_xor_check_test.sv]
module typed_frame_deframer_xor_check_test;
    import tfd_pkg::*;

    // item kinds on the command field
    localparam logic CMD_BYTE    = 1'b0;
    localparam logic CMD_TIMEOUT = 1'b1;

    // type byte that makes the four header bytes XOR to zero
    localparam logic [BYTE_W-1:0] BALANCED_TYPE = START_BYTE0 ^ START_BYTE1 ^ START_BYTE2;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 150;

    // raw values as written; the block keeps only the low bits of the code and length registers
    typedef struct {
        logic [CFG_DATA_W-1:0] oper_code, oper_len, param_code, param_len,
                               label_code, label_len, unknown_lim, drain_lim;
    } t_reg_set;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic [BYTE_W-1:0]     i_rx_byte;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CLASS_W-1:0]    o_frame_class;
    logic [CODE_W-1:0]     o_type_byte;
    logic [TOTAL_W-1:0]    o_byte_total;
    logic                  o_length_complete;
    logic                  o_checksum_good;

    int       fail_count;
    int       pending;
    int       frames_checked;
    logic     at_boundary;
    logic     in_header;

    t_reg_set regs;          // what the block currently holds
    logic     calm;          // no idling on either side while set
    int       items_sent;
    int       settings;

    typed_frame_deframer_xor_check u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_frame_class     (o_frame_class),
        .o_type_byte       (o_type_byte),
        .o_byte_total      (o_byte_total),
        .o_length_complete (o_length_complete),
        .o_checksum_good   (o_checksum_good)
    );

    typed_frame_deframer_xor_check_checker u_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_rx_byte         (i_rx_byte),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_frame_class     (o_frame_class),
        .i_type_byte       (o_type_byte),
        .i_byte_total      (o_byte_total),
        .i_length_complete (o_length_complete),
        .i_checksum_good   (o_checksum_good),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_frames_checked  (frames_checked),
        .o_at_boundary     (at_boundary),
        .o_in_header       (in_header)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #3_000_000;
        $display("Mismatches found");
        $finish;
    end

    // result side: stall at random about 14 percent of the time, never while calm
    always @(negedge i_clk)
        i_out_stall <= !calm && ($urandom_range(0, 99) < 14);

    // Hold the item until the block takes it; idle at random beforehand.
    task automatic send_item(input logic is_timeout, input logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(0, 99) < 14) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= is_timeout;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Bias bytes toward the start pattern and known type codes.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return START_BYTE0;
            1:       return START_BYTE1;
            2:       return START_BYTE2;
            3:       return regs.oper_code[CODE_W-1:0];
            4:       return BALANCED_TYPE;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    task automatic send_header(input logic [BYTE_W-1:0] type_code);
        send_item(CMD_BYTE, START_BYTE0);
        send_item(CMD_BYTE, START_BYTE1);
        send_item(CMD_BYTE, START_BYTE2);
        send_item(CMD_BYTE, type_code);
    endtask

    // Push bytes or timeouts until the deframer waits for a fresh header.
    task automatic realign();
        while (!at_boundary)
            send_item(in_header ? CMD_BYTE : CMD_TIMEOUT, pick_byte());
    endtask

    // One frame with random body; broken frames carry a damaged start pattern
    // and go to the drain path. Each runs to full length or is cut by a timeout;
    // about half with two or more body bytes get a balanced XOR for the checksum.
    task automatic send_frame(input logic broken);
        logic [BYTE_W-1:0] hdr [4];
        logic [BYTE_W-1:0] run;
        logic [BYTE_W-1:0] b;
        logic              early;
        logic              balance;
        int                target;
        int                n;
        int                bad;
        hdr[0] = START_BYTE0;
        hdr[1] = START_BYTE1;
        hdr[2] = START_BYTE2;
        case ($urandom_range(0, 4))
            0:       hdr[3] = regs.oper_code[CODE_W-1:0];
            1:       hdr[3] = regs.param_code[CODE_W-1:0];
            2:       hdr[3] = regs.label_code[CODE_W-1:0];
            3:       hdr[3] = BALANCED_TYPE;
            default: hdr[3] = BYTE_W'($urandom);
        endcase
        // body length follows the type priority: operating, parameter, label
        if (broken) begin
            bad             = int'($urandom_range(0, 2));
            hdr[bad[1:0]]   = hdr[bad[1:0]] ^ BYTE_W'($urandom_range(1, 255));
            target          = int'(regs.drain_lim[LIMIT_W-1:0]);
        end else if (hdr[3] == regs.oper_code[CODE_W-1:0]) begin
            target = int'(regs.oper_len[LEN_W-1:0]);
        end else if (hdr[3] == regs.param_code[CODE_W-1:0]) begin
            target = int'(regs.param_len[LEN_W-1:0]);
        end else if (hdr[3] == regs.label_code[CODE_W-1:0]) begin
            target = int'(regs.label_len[LEN_W-1:0]);
        end else begin
            target = int'(regs.unknown_lim[LIMIT_W-1:0]);
        end
        early   = (target > 0) && ((target > 40) || ($urandom_range(0, 99) < 30));
        n       = early ? int'($urandom_range(0, (target - 1 < 24) ? target - 1 : 24))
                        : target;
        balance = 1'($urandom_range(0, 1));
        run     = '0;
        for (int i = 0; i < 4; i++) begin
            // a stray timeout inside the header must be dropped
            if (i > 0 && $urandom_range(0, 99) < 8)
                send_item(CMD_TIMEOUT, pick_byte());
            send_item(CMD_BYTE, hdr[i[1:0]]);
            run = run ^ hdr[i[1:0]];
        end
        for (int i = 0; i < n; i++) begin
            b = (balance && i == n - 2) ? run : BYTE_W'($urandom);
            send_item(CMD_BYTE, b);
            run = run ^ b;
        end
        if (early)
            send_item(CMD_TIMEOUT, pick_byte());
    endtask

    // Finish the open frame, drop valid and wait out every report.
    task automatic settle();
        realign();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_registers(input t_reg_set s);
        write_reg(REG_OPER_CODE, s.oper_code);
        write_reg(REG_OPER_LEN, s.oper_len);
        write_reg(REG_PARAM_CODE, s.param_code);
        write_reg(REG_PARAM_LEN, s.param_len);
        write_reg(REG_LABEL_CODE, s.label_code);
        write_reg(REG_LABEL_LEN, s.label_len);
        write_reg(REG_UNKNOWN_LIM, s.unknown_lim);
        write_reg(REG_DRAIN_LIM, s.drain_lim);
        i_cfg_valid <= 1'b0;
        regs = s;
        settings++;
    endtask

    initial begin : stimulus
        t_reg_set s;
        int       phase_start;
        int       pick;
        i_rst_n          = 1'b0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = REG_OPER_CODE;
        i_cfg_data       = '0;
        i_in_valid       = 1'b0;
        i_command        = CMD_BYTE;
        i_rx_byte        = '0;
        calm             = 1'b0;
        items_sent       = 0;
        settings         = 1;
        regs.oper_code   = CFG_DATA_W'(RST_OPER_CODE);
        regs.oper_len    = CFG_DATA_W'(RST_OPER_LEN);
        regs.param_code  = CFG_DATA_W'(RST_PARAM_CODE);
        regs.param_len   = CFG_DATA_W'(RST_PARAM_LEN);
        regs.label_code  = CFG_DATA_W'(RST_LABEL_CODE);
        regs.label_len   = CFG_DATA_W'(RST_LABEL_LEN);
        regs.unknown_lim = RST_UNKNOWN_LIM;
        regs.drain_lim   = RST_DRAIN_LIM;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part, reset register values.
        // Header split by a timeout, then an empty operating body cut by a timeout.
        send_item(CMD_BYTE, START_BYTE0);
        send_item(CMD_BYTE, START_BYTE1);
        send_item(CMD_TIMEOUT, 8'hFF);
        send_item(CMD_BYTE, START_BYTE2);
        send_item(CMD_BYTE, RST_OPER_CODE);
        send_item(CMD_TIMEOUT, 8'h00);
        // empty parameter frame
        send_header(RST_PARAM_CODE);
        send_item(CMD_TIMEOUT, 8'h5A);
        // label frame whose leading bytes XOR to zero, cut short
        send_header(RST_LABEL_CODE);
        send_item(CMD_BYTE, BALANCED_TYPE ^ RST_LABEL_CODE);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_TIMEOUT, 8'h00);
        // unknown type that balances the header on its own
        send_header(BALANCED_TYPE);
        send_item(CMD_BYTE, 8'hA5);
        send_item(CMD_TIMEOUT, 8'h00);
        // missing start pattern, one drained byte, then a timeout
        send_item(CMD_BYTE, 8'h40);
        send_item(CMD_BYTE, START_BYTE1);
        send_item(CMD_BYTE, START_BYTE2);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'h80);
        send_item(CMD_TIMEOUT, 8'hFF);

        // Random part: one register setting per phase, reset values first.
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                settle();
                // small lengths by default; bit 10 of the data is dropped for lengths
                s.oper_code   = CFG_DATA_W'($urandom_range(0, 2047));
                s.param_code  = CFG_DATA_W'($urandom_range(0, 2047));
                s.label_code  = CFG_DATA_W'($urandom_range(0, 2047));
                s.oper_len    = CFG_DATA_W'($urandom_range(1, 12) |
                                            ($urandom_range(0, 1) << 10));
                s.param_len   = CFG_DATA_W'($urandom_range(1, 12) |
                                            ($urandom_range(0, 1) << 10));
                s.label_len   = CFG_DATA_W'($urandom_range(1, 40) |
                                            ($urandom_range(0, 1) << 10));
                s.unknown_lim = CFG_DATA_W'($urandom_range(1, 20));
                s.drain_lim   = CFG_DATA_W'($urandom_range(1, 20));
                case (p)
                    1: begin
                        // widest lengths and limits everywhere
                        s.oper_code   = '0;
                        s.param_code  = '1;
                        s.label_code  = 11'h080;
                        s.oper_len    = 11'h3FF;
                        s.param_len   = '1;
                        s.label_len   = 11'h3FF;
                        s.unknown_lim = '1;
                        s.drain_lim   = '1;
                    end
                    2: begin
                        // zero lengths and limits: frames end on the type byte
                        s.oper_len    = 11'h400;
                        s.param_len   = 11'h400;
                        s.label_len   = '0;
                        s.unknown_lim = '0;
                        s.drain_lim   = '0;
                    end
                    3: begin
                        s.oper_len    = 11'd1;
                        s.param_len   = 11'd1;
                        s.label_len   = 11'd1;
                        s.unknown_lim = 11'd1;
                        s.drain_lim   = 11'd1;
                    end
                    4: begin
                        // shared type code: operating wins
                        s.param_code = s.oper_code;
                        s.label_code = s.oper_code;
                    end
                    default: ;
                endcase
                load_registers(s);
            end
            calm = (p == 6);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                pick = int'($urandom_range(0, 99));
                if (pick < 65) begin
                    // mostly aligned frames, a few land on a stale header
                    if (pick < 55)
                        realign();
                    send_frame(1'b0);
                end else if (pick < 85) begin
                    realign();
                    send_frame(1'b1);
                end else begin
                    repeat ($urandom_range(1, 6))
                        send_item($urandom_range(0, 99) < 20 ? CMD_TIMEOUT : CMD_BYTE,
                                  pick_byte());
                end
            end
        end
        calm = 1'b0;
        settle();

        $display("Drove %0d items under %0d register settings, zero and widest lengths among them.",
                 items_sent, settings);
        $display("Compared %0d frame reports field by field.", frames_checked);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
hdl/tfd_pkg.sv
hdl/typed_frame_deframer_xor_check.sv
tb/typed_frame_deframer_xor_check_checker.sv
tb/typed_frame_deframer_xor_check_test.sv
